### rtl/core/midi_voice_allocator_unit_defines.svh
// Assertion macros used by the voice allocator controller.
`ifndef MIDI_VOICE_ALLOCATOR_UNIT_DEFINES_SVH
`define MIDI_VOICE_ALLOCATOR_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voice allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define MVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voice allocator check failed");

`endif

### rtl/core/mva_pkg.sv
package mva_pkg;

    // MIDI command nibbles and controller numbers.
    localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
    localparam logic [3:0] CMD_CONTROL  = 4'hB;
    localparam logic [6:0] CTL_ALL_OFF  = 7'h7B;

    // Result action codes.
    localparam logic [2:0] ACT_IGNORED  = 3'd0;
    localparam logic [2:0] ACT_NOTE_ON  = 3'd1;
    localparam logic [2:0] ACT_NOTE_OFF = 3'd2;
    localparam logic [2:0] ACT_ALL_OFF  = 3'd3;
    localparam logic [2:0] ACT_DROPPED  = 3'd4;

    // Message class decoded in the search step.
    typedef enum logic [1:0] {
        K_OTHER    = 2'd0,
        K_NOTE_ON  = 2'd1,
        K_NOTE_OFF = 2'd2,
        K_ALL_OFF  = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the incoming message
        logic find;   // compare all slots and register the hit vector
        logic apply;  // update the slot table and load the result register
    } t_dp_cmd;

endpackage

### rtl/core/mva_ctrl.sv
`include "midi_voice_allocator_unit_defines.svh"

module mva_ctrl
    import mva_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_FIND  = 3'b010,
        S_APPLY = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_beat;
    logic   apply_go;

    // A new message is taken only between items; the result register may still be full.
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_beat     = i_in_valid && o_in_ready;
    assign apply_go    = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load  = in_beat;
    assign o_cmd.find  = (r_state == S_FIND);
    assign o_cmd.apply = apply_go;

    // Sequencer: capture, search, then apply once the result register is free.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (apply_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // The result beat stays valid until it is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (apply_go) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `MVA_ASSERT_NEXT(a_beat_starts_search, i_clk, i_rst_n, in_beat, r_state == S_FIND)
    `MVA_ASSERT_NEXT(a_search_one_cycle, i_clk, i_rst_n, r_state == S_FIND, r_state == S_APPLY)
    `MVA_ASSERT_SAME(a_result_from_apply, i_clk, i_rst_n, $rose(r_out_valid), $past(apply_go))

endmodule

### rtl/core/mva_datapath.sv
module mva_datapath
    import mva_pkg::*;
#(
    parameter int VOICE_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_cmd    i_cmd,
    input  logic [7:0] i_status_byte,
    input  logic [6:0] i_data_one,
    input  logic [6:0] i_data_two,
    output logic [2:0] o_action,
    output logic [2:0] o_voice,
    output logic [7:0] o_fwd_status,
    output logic [6:0] o_fwd_data_one,
    output logic [6:0] o_fwd_data_two
);

    localparam int IDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    logic [6:0]             r_slot_note [VOICE_COUNT];
    logic [7:0]             r_status;
    logic [6:0]             r_d1;
    logic [6:0]             r_d2;
    t_kind                  r_kind;
    logic [VOICE_COUNT-1:0] r_hit;
    logic [2:0]             r_action;
    logic [2:0]             r_voice;

    t_kind                  kind;
    logic [6:0]             wanted;
    logic [VOICE_COUNT-1:0] hit;
    logic                   hit_any;
    logic [IDX_W-1:0]       hit_idx;
    logic [IDX_W+2:0]       hit_idx_ext;
    logic [2:0]             n_action;
    logic [2:0]             n_voice;
    logic                   wr_en;
    logic                   clr_all;
    logic [6:0]             wr_note;

    // Classify the captured message.
    always_comb begin
        if (r_status[7:4] == CMD_CONTROL && r_d1 == CTL_ALL_OFF) begin
            kind = K_ALL_OFF;
        end else if ((r_status[7:4] == CMD_NOTE_ON && r_d2 == 7'd0) ||
                     r_status[7:4] == CMD_NOTE_OFF) begin
            kind = K_NOTE_OFF;
        end else if (r_status[7:4] == CMD_NOTE_ON) begin
            kind = K_NOTE_ON;
        end else begin
            kind = K_OTHER;
        end
    end

    // A note-off looks for its note, a note-on for a free slot.
    assign wanted = (kind == K_NOTE_OFF) ? r_d1 : 7'd0;

    always_comb begin
        for (int k = 0; k < VOICE_COUNT; k++) begin
            hit[k] = (r_slot_note[k] == wanted);
        end
    end

    // Lowest matching slot from the registered hit vector.
    always_comb begin
        hit_idx = '0;
        for (int k = VOICE_COUNT - 1; k >= 0; k--) begin
            if (r_hit[k]) begin
                hit_idx = IDX_W'(k);
            end
        end
    end

    assign hit_any     = |r_hit;
    assign hit_idx_ext = {3'b000, hit_idx};

    // Result and table update; a note-off for note zero is always dropped.
    always_comb begin
        n_action = ACT_IGNORED;
        n_voice  = 3'd0;
        wr_en    = 1'b0;
        clr_all  = 1'b0;
        wr_note  = 7'd0;
        case (r_kind)
            K_ALL_OFF: begin
                n_action = ACT_ALL_OFF;
                clr_all  = 1'b1;
            end
            K_NOTE_OFF: begin
                n_action = ACT_DROPPED;
                if (r_d1 != 7'd0 && hit_any) begin
                    n_action = ACT_NOTE_OFF;
                    n_voice  = hit_idx_ext[2:0];
                    wr_en    = 1'b1;
                end
            end
            K_NOTE_ON: begin
                n_action = ACT_DROPPED;
                if (hit_any) begin
                    n_action = ACT_NOTE_ON;
                    n_voice  = hit_idx_ext[2:0];
                    wr_en    = 1'b1;
                    wr_note  = r_d1;
                end
            end
            K_OTHER: begin
                n_action = ACT_IGNORED;
            end
            default: begin
                n_action = ACT_IGNORED;
            end
        endcase
    end

    // Slot table: every slot free after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VOICE_COUNT; k++) begin
                r_slot_note[k] <= 7'd0;
            end
        end else if (i_cmd.apply) begin
            if (clr_all) begin
                for (int k = 0; k < VOICE_COUNT; k++) begin
                    r_slot_note[k] <= 7'd0;
                end
            end else if (wr_en) begin
                r_slot_note[hit_idx] <= wr_note;
            end
        end
    end

    // Message capture, search results and the result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= i_status_byte;
            r_d1     <= i_data_one;
            r_d2     <= i_data_two;
        end
        if (i_cmd.find) begin
            r_kind <= kind;
            r_hit  <= hit;
        end
        if (i_cmd.apply) begin
            r_action       <= n_action;
            r_voice        <= n_voice;
            o_fwd_status   <= r_status;
            o_fwd_data_one <= r_d1;
            o_fwd_data_two <= r_d2;
        end
    end

    assign o_action = r_action;
    assign o_voice  = r_voice;

endmodule

### rtl/core/midi_voice_allocator_unit.sv
// Polyphonic MIDI voice allocator. Each input beat is one three-byte MIDI
// message; each one yields exactly one result beat that names the action
// taken, the voice slot chosen and an echo of the message. Note-ons take the
// lowest free slot, note-offs (and note-ons with velocity zero) free the lowest
// slot holding that note, and control change 0x7B clears every slot and is
// reported as a broadcast. The controller captures each message, compares all
// slots in the search step and then applies the update and loads the result
// register in the apply step. The apply step waits while the result register
// still holds an untaken beat; no new message is taken until that apply step
// is done.
module midi_voice_allocator_unit
    import mva_pkg::*;
#(
    parameter int VOICE_COUNT = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_status_byte,
    input  logic [6:0] i_data_one,
    input  logic [6:0] i_data_two,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_action,
    output logic [2:0] o_voice,
    output logic [7:0] o_fwd_status,
    output logic [6:0] o_fwd_data_one,
    output logic [6:0] o_fwd_data_two
);

    t_dp_cmd dp_cmd;

    // Sequencer and handshakes.
    mva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (dp_cmd)
    );

    // Slot table, search and result register.
    mva_datapath #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_status_byte  (i_status_byte),
        .i_data_one     (i_data_one),
        .i_data_two     (i_data_two),
        .o_action       (o_action),
        .o_voice        (o_voice),
        .o_fwd_status   (o_fwd_status),
        .o_fwd_data_one (o_fwd_data_one),
        .o_fwd_data_two (o_fwd_data_two)
    );

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import mva_pkg::*;

    localparam int VOICES      = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_REPORTS = 10;

    // One MIDI message as it goes onto the input channel; a hold marker makes
    // the feeder wait until every outstanding result has come back.
    typedef struct {
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] level;
        bit         hold;
    } t_midi_msg;

    // One result beat as the allocator should report it.
    typedef struct {
        logic [2:0] action;
        logic [2:0] voice;
        logic [7:0] status;
        logic [6:0] note;
        logic [6:0] level;
    } t_routing;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] status    = '0;
    logic [6:0] note      = '0;
    logic [6:0] level     = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] action;
    logic [2:0] voice;
    logic [7:0] fwd_status;
    logic [6:0] fwd_note;
    logic [6:0] fwd_level;

    t_midi_msg  msg_q[$];
    t_routing   routing_q[$];
    logic [6:0] slot_note [VOICES];
    logic       in_beat_taken = 1'b0;
    int         n_items       = 0;
    int         beats_in      = 0;
    int         beats_out     = 0;
    int         errors        = 0;
    int         cycles        = 0;
    int         action_seen [5];

    midi_voice_allocator_unit #(
        .VOICE_COUNT(VOICES)
    ) u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_status_byte (status),
        .i_data_one    (note),
        .i_data_two    (level),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_action      (action),
        .o_voice       (voice),
        .o_fwd_status  (fwd_status),
        .o_fwd_data_one(fwd_note),
        .o_fwd_data_two(fwd_level)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Works out the result of one message and updates the slot table.
    function automatic t_routing route_message(input t_midi_msg m);
        t_routing   r;
        logic [3:0] cmd;
        int         hit;
        cmd      = m.status[7:4];
        hit      = -1;
        r.action = ACT_IGNORED;
        r.voice  = '0;
        r.status = m.status;
        r.note   = m.note;
        r.level  = m.level;
        if (cmd == CMD_CONTROL && m.note == CTL_ALL_OFF) begin
            for (int k = 0; k < VOICES; k++) slot_note[k] = '0;
            r.action = ACT_ALL_OFF;
        end else if ((cmd == CMD_NOTE_ON && m.level == 0) || cmd == CMD_NOTE_OFF) begin
            // Note zero never matches, since zero marks a free slot.
            r.action = ACT_DROPPED;
            if (m.note != 0) begin
                for (int k = VOICES - 1; k >= 0; k--) begin
                    if (slot_note[k] == m.note) hit = k;
                end
                if (hit >= 0) begin
                    slot_note[hit] = '0;
                    r.action       = ACT_NOTE_OFF;
                    r.voice        = hit[2:0];
                end
            end
        end else if (cmd == CMD_NOTE_ON) begin
            for (int k = VOICES - 1; k >= 0; k--) begin
                if (slot_note[k] == 0) hit = k;
            end
            if (hit >= 0) begin
                // A note-on for note zero leaves the slot free.
                slot_note[hit] = m.note;
                r.action       = ACT_NOTE_ON;
                r.voice        = hit[2:0];
            end else begin
                r.action = ACT_DROPPED;
            end
        end
        return r;
    endfunction

    task automatic add_msg(input logic [7:0] s, input logic [6:0] n, input logic [6:0] l);
        msg_q.push_back('{s, n, l, 1'b0});
        n_items++;
    endtask

    // Input beats feed the prediction; result beats are checked against it.
    always @(posedge clk) begin : monitor
        t_routing want;
        t_midi_msg got_in;
        cycles++;
        in_beat_taken <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready) begin
            got_in = '{status, note, level, 1'b0};
            routing_q.push_back(route_message(got_in));
            beats_in++;
        end
        if (rst_n && out_valid && out_ready) begin
            beats_out++;
            if (routing_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] unexpected result beat: action %0d voice %0d status %h",
                             $realtime, action, voice, fwd_status);
            end else begin
                want = routing_q.pop_front();
                action_seen[want.action]++;
                if (action !== want.action || voice !== want.voice ||
                    fwd_status !== want.status || fwd_note !== want.note ||
                    fwd_level !== want.level) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display({"[%0t] result %0d mismatch: expected act %0d voice %0d ",
                                  "msg %h %h %h, got act %0d voice %0d msg %h %h %h"},
                                 $realtime, beats_out, want.action, want.voice, want.status,
                                 want.note, want.level, action, voice, fwd_status, fwd_note,
                                 fwd_level);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("midi_voice_allocator_unit verification failed");
            $finish;
        end
    end

    // Feeder and receiver. The idle mix changes with progress: first the
    // sender is the lighter idler, then the receiver, and at the end neither.
    always @(negedge clk) begin : feeder
        t_midi_msg head;
        int send_idle;
        int recv_idle;
        if (beats_in < n_items / 3) begin
            send_idle = 31;
            recv_idle = 72;
        end else if (beats_in < 2 * n_items / 3) begin
            send_idle = 72;
            recv_idle = 31;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
        if (rst_n) begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
            if (!in_valid || in_beat_taken) begin
                if (msg_q.size() != 0 && msg_q[0].hold) begin
                    in_valid <= 1'b0;
                    if (routing_q.size() == 0) void'(msg_q.pop_front());
                end else if (msg_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                    head = msg_q.pop_front();
                    in_valid <= 1'b1;
                    status   <= head.status;
                    note     <= head.note;
                    level    <= head.level;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        logic [3:0] chan;
        logic [6:0] pick_note;
        logic [6:0] pick_level;
        logic [7:0] pick_status;
        int         pick;
        int         routed;

        foreach (slot_note[k]) slot_note[k] = '0;
        foreach (action_seen[k]) action_seen[k] = 0;

        // Directed part: note zero quirks, misses, a full table, note-on with
        // zero velocity, non-note commands, data bytes as status, all-off.
        add_msg({CMD_NOTE_ON, 4'h0}, 7'd0, 7'd127);
        add_msg({CMD_NOTE_ON, 4'h0}, 7'd60, 7'd1);
        add_msg({CMD_NOTE_OFF, 4'h0}, 7'd0, 7'd64);
        add_msg({CMD_NOTE_OFF, 4'hF}, 7'd99, 7'd0);
        for (int k = 1; k < VOICES; k++) add_msg({CMD_NOTE_ON, 4'(k)}, 7'(60 + k), 7'd127);
        add_msg({CMD_NOTE_ON, 4'hF}, 7'd127, 7'd127);
        add_msg({CMD_NOTE_ON, 4'h3}, 7'd61, 7'd0);
        add_msg({CMD_NOTE_ON, 4'hA}, 7'd127, 7'd127);
        add_msg({CMD_NOTE_OFF, 4'h0}, 7'd60, 7'd127);
        add_msg(8'h00, 7'd0, 7'd0);
        add_msg(8'h7F, 7'd127, 7'd127);
        add_msg({CMD_CONTROL, 4'h0}, 7'h7A, 7'd127);
        add_msg({CMD_CONTROL, 4'hF}, CTL_ALL_OFF, 7'd0);
        add_msg(8'hA5, 7'd60, 7'd60);
        add_msg(8'hC3, 7'd5, 7'd0);
        add_msg(8'hE0, 7'd127, 7'd127);
        add_msg(8'hFF, 7'd127, 7'd0);
        add_msg({CMD_NOTE_ON, 4'h2}, 7'd5, 7'd9);
        add_msg({CMD_NOTE_ON, 4'h2}, 7'd5, 7'd9);
        add_msg({CMD_NOTE_OFF, 4'h1}, 7'd5, 7'd0);
        msg_q.push_back('{8'h00, 7'd0, 7'd0, 1'b1});

        // Random part: mostly note traffic on a small pool of notes so that
        // slots fill, match and miss; some all-off, the rest raw noise.
        routed = 0;
        while (n_items < 1150) begin
            pick       = $urandom_range(0, 99);
            chan       = 4'($urandom);
            pick_note  = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(1, 24));
            pick_level = 7'($urandom_range(1, 127));
            if (pick < 45) begin
                if ($urandom_range(0, 15) == 0) pick_level = '0;
                add_msg({CMD_NOTE_ON, chan}, pick_note, pick_level);
                routed++;
            end else if (pick < 75) begin
                pick_level = 7'($urandom);
                add_msg({CMD_NOTE_OFF, chan}, pick_note, pick_level);
                routed++;
            end else if (pick < 80) begin
                pick_level = 7'($urandom);
                add_msg({CMD_CONTROL, chan}, CTL_ALL_OFF, pick_level);
                routed++;
            end else begin
                pick_status = 8'($urandom);
                pick_note   = 7'($urandom);
                pick_level  = 7'($urandom);
                add_msg(pick_status, pick_note, pick_level);
            end
            if (routed == 600 && pick < 80) msg_q.push_back('{8'h00, 7'd0, 7'd0, 1'b1});
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (msg_q.size() != 0 || in_valid) @(posedge clk);
        while (routing_q.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d messages and checked %0d result beats.", beats_in, beats_out);
        $display("Note-ons routed %0d, note-offs routed %0d, all-off %0d, dropped %0d, ignored %0d.",
                 action_seen[ACT_NOTE_ON], action_seen[ACT_NOTE_OFF], action_seen[ACT_ALL_OFF],
                 action_seen[ACT_DROPPED], action_seen[ACT_IGNORED]);
        if (errors == 0) begin
            $display("midi_voice_allocator_unit verification clean");
        end else begin
            $display("%0d mismatches in total.", errors);
            $display("midi_voice_allocator_unit verification failed");
        end
        $finish;
    end

endmodule
